// File: design/cla_pkg.sv
// Shared types and codes for the capacity-limited cell assigner.
package cla_pkg;

	localparam int ID_W    = 32;
	localparam int KIND_W  = 8;
	localparam int COORD_W = 32;
	localparam int AMT_W   = 32;
	localparam int CAP_W   = 8;
	localparam int OP_W    = 2;

	localparam logic [OP_W-1:0] OP_SEED  = 2'd0;
	localparam logic [OP_W-1:0] OP_CAND  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	localparam logic OUT_ASSIGNED   = 1'b0;
	localparam logic OUT_UNASSIGNED = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]           op;
		logic [ID_W-1:0]           actor_id;
		logic [KIND_W-1:0]         actor_kind;
		logic signed [COORD_W-1:0] cell_x;
		logic signed [COORD_W-1:0] cell_y;
		logic [AMT_W-1:0]          seed_amount;
		logic                      has_candidate;
		logic                      first_of_actor;
		logic                      last_of_actor;
	} item_t;

	typedef struct packed {
		logic                      outcome;
		logic [ID_W-1:0]           actor_id;
		logic [KIND_W-1:0]         actor_kind;
		logic signed [COORD_W-1:0] cell_x;
		logic signed [COORD_W-1:0] cell_y;
		logic                      overflow;
	} result_t;

endpackage

// File: design/capacity_limited_cell_assigner.sv
// Top level: transaction ports, capacity register and result register around the table sequencer.
//
// Assigns actors to grid cells first fit under a per-cell capacity. One transaction is taken
// at a time: in_stall stays high while the sequencer walks its tables. The seen-id table and
// the cell table share one comparator and are scanned one entry per cycle. A candidate that
// opens an actor's run scans the seen-id table and then, while the run is open, the cell
// table; a seed scans only the cell table, and a clear resets the fill counts. Tables need
// no clearing pass after reset; fill counts mark the valid entries. A result waits in its own
// register, so the next transaction is taken while it is still stalled on the output.
module capacity_limited_cell_assigner #(
	parameter int CELL_SLOTS = 256,
	parameter int SEEN_SLOTS = 256
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [cla_pkg::CAP_W-1:0]           cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [cla_pkg::OP_W-1:0]            op,
	input  logic [cla_pkg::ID_W-1:0]            actor_id,
	input  logic [cla_pkg::KIND_W-1:0]          actor_kind,
	input  logic signed [cla_pkg::COORD_W-1:0]  cell_x,
	input  logic signed [cla_pkg::COORD_W-1:0]  cell_y,
	input  logic [cla_pkg::AMT_W-1:0]           seed_amount,
	input  logic                                has_candidate,
	input  logic                                first_of_actor,
	input  logic                                last_of_actor,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                outcome,
	output logic [cla_pkg::ID_W-1:0]            out_actor_id,
	output logic [cla_pkg::KIND_W-1:0]          out_actor_kind,
	output logic signed [cla_pkg::COORD_W-1:0]  out_cell_x,
	output logic signed [cla_pkg::COORD_W-1:0]  out_cell_y,
	output logic                                overflow
);

	logic [cla_pkg::CAP_W-1:0] cap_q;
	logic                      out_valid_q;
	cla_pkg::result_t          out_q;
	cla_pkg::item_t            item;
	cla_pkg::result_t          res;
	logic                      core_ready;
	logic                      start;
	logic                      res_valid;
	logic                      res_take;

	assign item = '{
		op:             op,
		actor_id:       actor_id,
		actor_kind:     actor_kind,
		cell_x:         cell_x,
		cell_y:         cell_y,
		seed_amount:    seed_amount,
		has_candidate:  has_candidate,
		first_of_actor: first_of_actor,
		last_of_actor:  last_of_actor
	};

	assign in_stall = !core_ready;
	assign start    = in_valid && core_ready;
	assign res_take = !out_valid_q || !out_stall;

	cla_core #(
		.CELL_SLOTS (CELL_SLOTS),
		.SEEN_SLOTS (SEEN_SLOTS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item),
		.cap       (cap_q),
		.ready     (core_ready),
		.res_valid (res_valid),
		.res       (res),
		.res_take  (res_take)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= cla_pkg::CAP_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (res_take) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign outcome        = out_q.outcome;
	assign out_actor_id   = out_q.actor_id;
	assign out_actor_kind = out_q.actor_kind;
	assign out_cell_x     = out_q.cell_x;
	assign out_cell_y     = out_q.cell_y;
	assign overflow       = out_q.overflow;

endmodule

// File: design/cla_core.sv
// Table sequencer: seen-id and cell tables scanned through one shared comparator.
module cla_core #(
	parameter int CELL_SLOTS = 256,
	parameter int SEEN_SLOTS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  cla_pkg::item_t                  item,
	input  logic [cla_pkg::CAP_W-1:0]       cap,
	output logic                            ready,
	output logic                            res_valid,
	output cla_pkg::result_t                res,
	input  logic                            res_take
);

	localparam int CW = $clog2(CELL_SLOTS);
	localparam int SW = $clog2(SEEN_SLOTS);
	localparam int IW = ((CW > SW) ? CW : SW) + 1;
	localparam int KW = 2 * cla_pkg::COORD_W;
	localparam logic [CW:0] CELL_FULL = (CW+1)'(CELL_SLOTS);
	localparam logic [SW:0] SEEN_FULL = (SW+1)'(SEEN_SLOTS);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEEN_SCAN,
		S_CAND_CHK,
		S_CELL_SCAN,
		S_APPLY,
		S_EMIT
	} state_t;

	state_t                    state_q;
	logic [CW:0]               cell_fill_q;
	logic [SW:0]               seen_fill_q;
	logic                      run_skipped_q;
	logic                      run_assigned_q;
	logic                      overflow_q;
	logic [IW-1:0]             idx_q;
	logic                      pend_q;
	logic                      slot_ok_q;

	cla_pkg::item_t            item_q;
	cla_pkg::result_t          res_q;
	logic [IW-1:0]             cmp_idx_q;
	logic [CW-1:0]             slot_q;
	logic [cla_pkg::CAP_W-1:0] occ_q;

	logic [cla_pkg::ID_W-1:0]    seen_mem [SEEN_SLOTS];
	logic [cla_pkg::COORD_W-1:0] col_mem  [CELL_SLOTS];
	logic [cla_pkg::COORD_W-1:0] row_mem  [CELL_SLOTS];
	logic [cla_pkg::CAP_W-1:0]   occ_mem  [CELL_SLOTS];

	logic [cla_pkg::ID_W-1:0]    rd_id_q;
	logic [cla_pkg::COORD_W-1:0] rd_col_q;
	logic [cla_pkg::COORD_W-1:0] rd_row_q;
	logic [cla_pkg::CAP_W-1:0]   rd_occ_q;

	logic [KW-1:0]             scan_key;
	logic [KW-1:0]             scan_data;
	logic [IW-1:0]             scan_fill;
	logic                      in_scan;
	logic                      hit;
	logic                      scan_end;
	logic                      issue;
	logic                      seen_we;
	logic                      cell_add;
	logic                      run_open;
	logic                      to_cell;
	logic                      chk_miss;
	logic                      fit;
	logic                      cand_fit;
	logic                      cand_miss;
	logic                      apply_we;
	logic                      res_load;
	logic [cla_pkg::AMT_W:0]   seed_sum;
	logic [cla_pkg::CAP_W-1:0] occ_new;
	logic                      occ_we;
	logic [CW-1:0]             occ_waddr;
	logic [cla_pkg::CAP_W-1:0] occ_wdata;

	// shared comparator and scan control
	always_comb begin
		if (state_q == S_CELL_SCAN) begin
			scan_key  = {$unsigned(item_q.cell_x), $unsigned(item_q.cell_y)};
			scan_data = {rd_col_q, rd_row_q};
			scan_fill = IW'(cell_fill_q);
		end else begin
			scan_key  = {{(KW-cla_pkg::ID_W){1'b0}}, item_q.actor_id};
			scan_data = {{(KW-cla_pkg::ID_W){1'b0}}, rd_id_q};
			scan_fill = IW'(seen_fill_q);
		end
	end

	assign in_scan  = (state_q == S_SEEN_SCAN) || (state_q == S_CELL_SCAN);
	assign hit      = pend_q && (scan_key == scan_data);
	assign scan_end = hit || (idx_q == scan_fill);
	assign issue    = in_scan && !scan_end;
	assign seen_we  = (state_q == S_SEEN_SCAN) && scan_end && !hit && (seen_fill_q != SEEN_FULL);
	assign cell_add = (state_q == S_CELL_SCAN) && scan_end && !hit && (cell_fill_q != CELL_FULL);

	assign run_open  = !run_skipped_q && !run_assigned_q;
	assign to_cell   = run_open && item_q.has_candidate && (cap != '0);
	assign chk_miss  = run_open && !to_cell && item_q.last_of_actor;
	assign fit       = slot_ok_q && (occ_q < cap);
	assign cand_fit  = (item_q.op == cla_pkg::OP_CAND) && fit;
	assign cand_miss = (item_q.op == cla_pkg::OP_CAND) && !fit && item_q.last_of_actor;
	assign apply_we  = (state_q == S_APPLY) && fit;
	assign res_load  = ((state_q == S_CAND_CHK) && chk_miss) ||
	                   ((state_q == S_APPLY) && (cand_fit || cand_miss));

	assign seed_sum = (cla_pkg::AMT_W+1)'(occ_q) + (cla_pkg::AMT_W+1)'(item_q.seed_amount);

	always_comb begin
		if (item_q.op == cla_pkg::OP_SEED) begin
			occ_new = (seed_sum >= (cla_pkg::AMT_W+1)'(cap)) ? cap : seed_sum[cla_pkg::CAP_W-1:0];
		end else begin
			occ_new = occ_q + 1'b1;
		end
		if (cell_add) begin
			occ_we    = 1'b1;
			occ_waddr = cell_fill_q[CW-1:0];
			occ_wdata = '0;
		end else begin
			occ_we    = apply_we;
			occ_waddr = slot_q;
			occ_wdata = occ_new;
		end
	end

	// tables
	always_ff @(posedge clk) begin
		if (seen_we) begin
			seen_mem[seen_fill_q[SW-1:0]] <= item_q.actor_id;
		end
		if (issue && (state_q == S_SEEN_SCAN)) begin
			rd_id_q <= seen_mem[idx_q[SW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cell_add) begin
			col_mem[cell_fill_q[CW-1:0]] <= $unsigned(item_q.cell_x);
			row_mem[cell_fill_q[CW-1:0]] <= $unsigned(item_q.cell_y);
		end
		if (issue && (state_q == S_CELL_SCAN)) begin
			rd_col_q <= col_mem[idx_q[CW-1:0]];
			rd_row_q <= row_mem[idx_q[CW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (occ_we) begin
			occ_mem[occ_waddr] <= occ_wdata;
		end
		if (issue && (state_q == S_CELL_SCAN)) begin
			rd_occ_q <= occ_mem[idx_q[CW-1:0]];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (start) begin
			item_q <= item;
		end
		if (issue) begin
			cmp_idx_q <= idx_q;
		end
		if ((state_q == S_CELL_SCAN) && hit) begin
			slot_q <= cmp_idx_q[CW-1:0];
			occ_q  <= rd_occ_q;
		end else if (cell_add) begin
			slot_q <= cell_fill_q[CW-1:0];
			occ_q  <= '0;
		end
		if (res_load) begin
			res_q.actor_id   <= item_q.actor_id;
			res_q.actor_kind <= item_q.actor_kind;
			res_q.overflow   <= overflow_q;
			if ((state_q == S_APPLY) && cand_fit) begin
				res_q.outcome <= cla_pkg::OUT_ASSIGNED;
				res_q.cell_x  <= item_q.cell_x;
				res_q.cell_y  <= item_q.cell_y;
			end else begin
				res_q.outcome <= cla_pkg::OUT_UNASSIGNED;
				res_q.cell_x  <= '0;
				res_q.cell_y  <= '0;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cell_fill_q    <= '0;
			seen_fill_q    <= '0;
			run_skipped_q  <= 1'b0;
			run_assigned_q <= 1'b0;
			overflow_q     <= 1'b0;
			idx_q          <= '0;
			pend_q         <= 1'b0;
			slot_ok_q      <= 1'b0;
		end else begin
			if (issue) begin
				idx_q  <= idx_q + 1'b1;
				pend_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					idx_q  <= '0;
					pend_q <= 1'b0;
					if (start) begin
						case (item.op)
							cla_pkg::OP_CLEAR: begin
								cell_fill_q    <= '0;
								seen_fill_q    <= '0;
								run_skipped_q  <= 1'b0;
								run_assigned_q <= 1'b0;
								overflow_q     <= 1'b0;
							end
							cla_pkg::OP_SEED: begin
								state_q <= S_CELL_SCAN;
							end
							cla_pkg::OP_CAND: begin
								if (item.first_of_actor) begin
									run_assigned_q <= 1'b0;
									state_q        <= S_SEEN_SCAN;
								end else begin
									state_q <= S_CAND_CHK;
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SEEN_SCAN: begin
					if (scan_end) begin
						state_q       <= S_CAND_CHK;
						run_skipped_q <= hit;
						if (!hit) begin
							if (seen_fill_q == SEEN_FULL) begin
								overflow_q <= 1'b1;
							end else begin
								seen_fill_q <= seen_fill_q + 1'b1;
							end
						end
					end
				end
				S_CAND_CHK: begin
					idx_q  <= '0;
					pend_q <= 1'b0;
					if (to_cell) begin
						state_q <= S_CELL_SCAN;
					end else if (chk_miss) begin
						state_q <= S_EMIT;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_CELL_SCAN: begin
					if (scan_end) begin
						state_q <= S_APPLY;
						if (hit) begin
							slot_ok_q <= 1'b1;
						end else if (cell_fill_q == CELL_FULL) begin
							slot_ok_q  <= 1'b0;
							overflow_q <= 1'b1;
						end else begin
							slot_ok_q   <= 1'b1;
							cell_fill_q <= cell_fill_q + 1'b1;
						end
					end
				end
				S_APPLY: begin
					if (cand_fit) begin
						run_assigned_q <= 1'b1;
					end
					state_q <= (cand_fit || cand_miss) ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign ready     = (state_q == S_IDLE);
	assign res_valid = (state_q == S_EMIT);
	assign res       = res_q;

endmodule

// File: design/cla_checker.sv
// Port-level checks on the cell assigner, bound to the top level.
module cla_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic [cla_pkg::OP_W-1:0]            op,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic                                outcome,
	input logic [cla_pkg::ID_W-1:0]            out_actor_id,
	input logic signed [cla_pkg::COORD_W-1:0]  out_cell_x,
	input logic signed [cla_pkg::COORD_W-1:0]  out_cell_y
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_actor_id) && $stable(outcome))
		else $error("stalled result changed");

	// drop the cell of an unassigned actor
	a_unassigned_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (outcome == cla_pkg::OUT_UNASSIGNED) |-> (out_cell_x == 0) && (out_cell_y == 0))
		else $error("unassigned result carries a cell");

	// a candidate transaction occupies the sequencer
	a_cand_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == cla_pkg::OP_CAND) |=> in_stall)
		else $error("candidate transaction did not occupy the sequencer");

	// a result appears only after the sequencer was busy
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without sequencer activity");

endmodule

bind capacity_limited_cell_assigner cla_checker u_cla_checker (.*);
